### design/spq_pkg.sv
package spq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PRIO_W = 32;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // per-cell command, issued by the queue controller every cycle
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,   // take the incoming entry
      CELL_SHIFT_UP   = 2'd2,   // take the entry of the cell in front
      CELL_SHIFT_DOWN = 2'd3    // take the entry of the cell behind
   } cell_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] ent_data;
      logic signed [PRIO_W-1:0] ent_prio;
   } entry_type;

endpackage

### design/spq_if.sv
interface spq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic signed [spq_pkg::DATA_W-1:0]    item_data;
   logic signed [spq_pkg::PRIO_W-1:0]    item_priority;

   modport source (output valid, output mode, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input mode, input item_data, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic signed [spq_pkg::DATA_W-1:0]    out_data;
   logic signed [spq_pkg::PRIO_W-1:0]    out_priority;

   modport source (output valid, output status, output out_data, output out_priority,
                   input ready);
   modport sink   (input valid, input status, input out_data, input out_priority,
                   output ready);
endinterface

### design/spq_cell.sv
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_op_type   op,
   input  spq_pkg::entry_type     new_entry,
   input  spq_pkg::entry_type     front_entry,
   input  spq_pkg::entry_type     back_entry,
   output spq_pkg::entry_type     entry,
   output logic                   gt_new
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // strict compare keeps equal priorities in arrival order
   assign gt_new = $signed(entry_ff.ent_prio) > $signed(new_entry.ent_prio);
   assign entry  = entry_ff;

   always_comb begin
      case (op)
         spq_pkg::CELL_HOLD:       entry_in = entry_ff;
         spq_pkg::CELL_LOAD:       entry_in = new_entry;
         spq_pkg::CELL_SHIFT_UP:   entry_in = front_entry;
         spq_pkg::CELL_SHIFT_DOWN: entry_in = back_entry;
         default:                  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### design/sorted_priority_queue_core.sv
// Sorted priority queue built as a row of DEPTH shift cells.
// Channels: req (sink) carries one word per operation: mode selects insert or
// remove, item_data / item_priority give the entry on insert. rsp (source)
// returns exactly one word per request: status, and on a successful remove the
// data and priority of the front entry (lowest priority, oldest among equals);
// otherwise out_data and out_priority are zero.
// Operation: every cell compares its priority with the incoming one in
// parallel; on insert the cells behind the insertion point shift back by one
// and the hole takes the new entry, on remove all cells shift forward.
// Timing: the result word is registered, valid in the cycle after acceptance.
// One request is accepted per cycle while req.ready is high; the cost per
// request is a single compare across the cell row plus the shift.
// Stall: the result sits in an output register; while it waits, a new request
// is still taken if rsp.ready is high in the same cycle, otherwise req.ready
// drops until the word is taken.
// Reset: synchronous, clears the entry count and the output valid; cell
// contents are don't-care until written. No clearing pass is needed.
// Full insert returns ST_FULL and drops the entry; remove on empty returns
// ST_EMPTY; neither changes the stored entries.
module sorted_priority_queue_core #(
   parameter int unsigned DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   // number of valid entries; cells [0, count) hold the sorted list
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   spq_pkg::status_type        status_ff;
   spq_pkg::status_type        status_in;
   spq_pkg::entry_type         out_ff;
   spq_pkg::entry_type         out_in;

   logic accept;
   logic is_insert;
   logic full;
   logic empty;
   logic do_insert;
   logic do_remove;

   spq_pkg::entry_type   new_entry;
   spq_pkg::entry_type   cell_entry [DEPTH];
   logic [DEPTH-1:0]     cell_gt;
   logic [DEPTH-1:0]     take;      // cell sits at or behind the insertion point
   spq_pkg::cell_op_type cell_op [DEPTH];

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign is_insert = (req.mode == spq_pkg::MODE_INSERT);
   assign full      = (count_ff == CntW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = accept && is_insert && !full;
   assign do_remove = accept && !is_insert && !empty;

   assign new_entry.ent_data = req.item_data;
   assign new_entry.ent_prio = req.item_priority;

   // take is monotone over the row: empty cells and cells with a strictly
   // larger priority, so the first set bit is the insertion point
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         take[i] = (CntW'(i) >= count_ff) || cell_gt[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (do_insert) begin
            if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
               cell_op[i] = spq_pkg::CELL_SHIFT_UP;
            end else if (take[i]) begin
               cell_op[i] = spq_pkg::CELL_LOAD;
            end else begin
               cell_op[i] = spq_pkg::CELL_HOLD;
            end
         end else if (do_remove) begin
            cell_op[i] = spq_pkg::CELL_SHIFT_DOWN;
         end else begin
            cell_op[i] = spq_pkg::CELL_HOLD;
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spq_pkg::entry_type front_entry;
      spq_pkg::entry_type back_entry;

      if (g == 0) begin : g_head
         assign front_entry = '0;
      end else begin : g_mid
         assign front_entry = cell_entry[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign back_entry = '0;
      end else begin : g_body
         assign back_entry = cell_entry[g+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (cell_op[g]),
         .new_entry   (new_entry),
         .front_entry (front_entry),
         .back_entry  (back_entry),
         .entry       (cell_entry[g]),
         .gt_new      (cell_gt[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CntW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      out_in    = out_ff;
      if (accept) begin
         out_in = '0;
         if (is_insert) begin
            status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
         end else if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            status_in = spq_pkg::ST_REMOVED;
            out_in    = cell_entry[0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.out_data     = out_ff.ent_data;
   assign rsp.out_priority = out_ff.ent_prio;

endmodule
